[sv/ust_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the UDP session table.
// No dependencies; used by ust_ctrl, ust_dp and the top level.
package ust_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = IW + 1;
	localparam logic [15:0] IDLE_RESET = 16'd30;
	localparam logic [31:0] ID_RESET = 32'd1;

	localparam logic [2:0] OP_TIME = 3'd0;
	localparam logic [2:0] OP_HELLO = 3'd1;
	localparam logic [2:0] OP_MSG = 3'd2;
	localparam logic [2:0] OP_BYE = 3'd3;
	localparam logic [2:0] OP_MALFORMED = 3'd5;

	localparam logic [3:0] K_WELCOME = 4'd0;
	localparam logic [3:0] K_ACK = 4'd1;
	localparam logic [3:0] K_DUP = 4'd2;
	localparam logic [3:0] K_BYE = 4'd3;
	localparam logic [3:0] K_CHAT = 4'd4;
	localparam logic [3:0] K_MALFORMED = 4'd5;
	localparam logic [3:0] K_FULL = 4'd6;
	localparam logic [3:0] K_HANDSHAKE = 4'd7;
	localparam logic [3:0] K_UNKNOWN = 4'd8;

	localparam logic [0:0] REG_IDLE_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DECIDE,
		ST_BCAST,
		ST_BC_RD
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic decide;
		logic bc_next;
		logic bc_emit;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic bcast;
		logic tgt;
		logic bc_end;
		logic out_free;
	} stat_t;

endpackage

[sv/ust_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the session table: sweep, decision and broadcast walk.
// Depends on ust_pkg.
module ust_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ust_pkg::stat_t st,
	output ust_pkg::cmd_t  cmd
);
	import ust_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (st.sweep_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (st.out_free) state_d = st.bcast ? ST_BCAST : ST_IDLE;
			end
			ST_BCAST: begin
				if (st.bc_end) state_d = ST_IDLE;
				else if (st.tgt) state_d = ST_BC_RD;
			end
			ST_BC_RD: begin
				if (st.out_free) state_d = ST_BCAST;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SWEEP: cmd.sweep = 1'b1;
			ST_DECIDE: cmd.decide = st.out_free;
			ST_BCAST: cmd.bc_next = !st.bc_end && !st.tgt;
			ST_BC_RD: cmd.bc_emit = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[sv/ust_dp.sv]
`timescale 1ns / 1ps
// Datapath of the session table: slot memories, flags, decision logic and
// the result register. Depends on ust_pkg; driven by ust_ctrl.
module ust_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ust_pkg::cmd_t       cmd,
	output ust_pkg::stat_t      st,
	input  logic [15:0]         idle_limit,
	input  logic [2:0]          in_opcode,
	input  logic [31:0]         in_ip,
	input  logic [15:0]         in_port,
	input  logic [31:0]         in_seq,
	input  logic [31:0]         in_now,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          out_kind,
	output logic [31:0]         out_ip,
	output logic [15:0]         out_port,
	output logic [31:0]         out_num,
	output logic [31:0]         out_seq,
	output logic                out_last
);
	import ust_pkg::*;

	localparam int N = TABLE_ENTRIES;

	logic [31:0] mem_ip [N];
	logic [15:0] mem_port [N];
	logic [31:0] mem_id [N];
	logic [31:0] mem_seq [N];
	logic [31:0] mem_seen [N];
	logic [31:0] ip_rd, id_rd, seq_rd, seen_rd;
	logic [15:0] port_rd;

	logic [N-1:0] active_q, verified_q, tgt_q;
	logic [31:0]  next_id_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]  op_q;
	logic [31:0] ip_q, seq_q, now_q, fid_q, flseq_q;
	logic [15:0] port_q;
	logic        found_q, fver_q, free_found_q;
	logic [IW-1:0] idx_q, free_idx_q;
	logic        valid_q;

	logic [IW-1:0] j, ra;
	logic        ev, act, hit;
	logic [N-1:0] tgt_new, tgt_shift;

	logic        emit, e_last, bump_id, set_new, set_ver, clr_slot, bcast;
	logic        we_all, we_seen, we_seq;
	logic [IW-1:0] waddr;
	logic [3:0]  e_kind;
	logic [31:0] e_ip, e_num, e_seq;
	logic [15:0] e_port;

	assign ra = cnt_q[IW-1:0];
	assign j = IW'(cnt_q - CW'(1));
	assign ev = active_q[j] && ((now_q - seen_rd) > {16'b0, idle_limit});
	assign act = active_q[j] && !ev;
	assign hit = act && ip_rd == ip_q && port_rd == port_q;
	assign tgt_new = active_q & verified_q & ~({{(N-1){1'b0}}, 1'b1} << idx_q);
	assign tgt_shift = tgt_q >> ra;

	always_comb begin
		emit = 1'b0; e_last = 1'b1; bump_id = 1'b0; set_new = 1'b0; set_ver = 1'b0;
		clr_slot = 1'b0; bcast = 1'b0; we_all = 1'b0; we_seen = 1'b0; we_seq = 1'b0;
		waddr = idx_q; e_kind = K_UNKNOWN; e_ip = ip_q; e_port = port_q;
		e_num = fid_q; e_seq = seq_q;
		case (op_q)
			OP_TIME: emit = 1'b0;
			OP_MALFORMED: begin
				emit = 1'b1; e_kind = K_MALFORMED; e_num = '0; e_seq = '0;
			end
			OP_HELLO: begin
				emit = 1'b1;
				e_kind = K_WELCOME;
				if (found_q) begin
					set_ver = 1'b1; we_seen = 1'b1; we_seq = 1'b1;
				end else begin
					bump_id = 1'b1;
					if (!free_found_q) begin
						e_kind = K_FULL; e_num = '0; e_seq = '0;
					end else begin
						waddr = free_idx_q; set_new = 1'b1; we_all = 1'b1;
						we_seen = 1'b1; we_seq = 1'b1; e_num = next_id_q;
					end
				end
			end
			default: begin
				emit = 1'b1;
				if (!found_q || !fver_q) begin
					e_kind = K_HANDSHAKE; e_num = '0; e_seq = '0;
				end else begin
					we_seen = 1'b1;
					if ($signed(seq_q) <= $signed(flseq_q)) begin
						e_kind = K_DUP;
					end else begin
						we_seq = 1'b1;
						if (op_q == OP_MSG) begin
							e_kind = K_ACK; bcast = 1'b1; e_last = (tgt_new == '0);
						end else if (op_q == OP_BYE) begin
							e_kind = K_BYE; clr_slot = 1'b1;
						end else begin
							e_kind = K_UNKNOWN;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ip_rd <= mem_ip[ra];
		port_rd <= mem_port[ra];
		id_rd <= mem_id[ra];
		seq_rd <= mem_seq[ra];
		seen_rd <= mem_seen[ra];
		if (cmd.decide) begin
			if (we_all) begin
				mem_ip[waddr] <= ip_q;
				mem_port[waddr] <= port_q;
				mem_id[waddr] <= next_id_q;
			end
			if (we_seen) mem_seen[waddr] <= now_q;
			if (we_seq) mem_seq[waddr] <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			verified_q <= '0;
			next_id_q <= ID_RESET;
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) cnt_q <= '0;
			else if (cmd.sweep || cmd.bc_next || cmd.bc_emit) cnt_q <= cnt_q + CW'(1);
			else if (cmd.decide) cnt_q <= '0;
			if (cmd.sweep && cnt_q != '0 && ev) begin
				active_q[j] <= 1'b0;
				verified_q[j] <= 1'b0;
			end
			if (cmd.decide) begin
				if (bump_id) next_id_q <= next_id_q + 32'd1;
				if (set_new) begin
					active_q[free_idx_q] <= 1'b1;
					verified_q[free_idx_q] <= 1'b1;
				end
				if (set_ver) verified_q[idx_q] <= 1'b1;
				if (clr_slot) begin
					active_q[idx_q] <= 1'b0;
					verified_q[idx_q] <= 1'b0;
				end
			end
			if ((cmd.decide && emit) || cmd.bc_emit) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_opcode; ip_q <= in_ip; port_q <= in_port;
			seq_q <= in_seq; now_q <= in_now;
			found_q <= 1'b0; free_found_q <= 1'b0;
		end
		if (cmd.sweep && cnt_q != '0) begin
			if (hit && !found_q) begin
				found_q <= 1'b1; idx_q <= j; fid_q <= id_rd;
				flseq_q <= seq_rd; fver_q <= verified_q[j];
			end
			if (!act && !free_found_q) begin
				free_found_q <= 1'b1; free_idx_q <= j;
			end
		end
		if (cmd.decide) tgt_q <= tgt_new;
		if (cmd.decide && emit) begin
			out_kind <= e_kind; out_ip <= e_ip; out_port <= e_port;
			out_num <= e_num; out_seq <= e_seq; out_last <= e_last;
		end else if (cmd.bc_emit) begin
			out_kind <= K_CHAT; out_ip <= ip_rd; out_port <= port_rd;
			out_num <= fid_q; out_seq <= seq_q; out_last <= ~|tgt_shift[N-1:1];
		end
	end

	assign out_valid = valid_q;
	assign st.sweep_last = cnt_q == CW'(N);
	assign st.bcast = bcast;
	assign st.bc_end = cnt_q == CW'(N);
	assign st.tgt = cnt_q != CW'(N) && tgt_q[ra];
	assign st.out_free = !valid_q || out_ready;

endmodule

[sv/udp_session_table_with_dedup_unit.sv]
`timescale 1ns / 1ps
// Top level of the UDP session table with duplicate suppression.
// Depends on ust_pkg, ust_ctrl and ust_dp.
//
// Each item makes one pass over the slot memories that ages out idle
// sessions and finds both the sender's slot and the lowest free slot; a
// decision step then applies the command and writes the first result. An
// accepted MSG then walks the slots again: each verified recipient takes a
// test step and a read-and-emit step, each other slot only the test step,
// and a final test step closes the walk. A result that is not yet taken
// holds back the decision step and each broadcast result. A result register
// on the output lets the next item start while the last result waits to
// be taken.
module udp_session_table_with_dedup_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[2:0], src_ip[34:3], src_port[50:35], seq[82:51], now_seconds[114:83]
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// reply_kind[3:0], dest_ip[35:4], dest_port[51:36], client_number[83:52],
	// seq_echo[115:84]
	output logic [119:0] m_tdata,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import ust_pkg::*;

	cmd_t cmd;
	stat_t st;
	logic [15:0] idle_limit_q;
	logic [3:0]  kind;
	logic [31:0] dip, num, sq;
	logic [15:0] dport;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDLE_LIMIT) ? {16'b0, idle_limit_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_IDLE_LIMIT) begin
			idle_limit_q <= pwdata[15:0];
		end
	end

	ust_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.st(st), .cmd(cmd)
	);

	ust_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .idle_limit(idle_limit_q),
		.in_opcode(s_tdata[2:0]), .in_ip(s_tdata[34:3]), .in_port(s_tdata[50:35]),
		.in_seq(s_tdata[82:51]), .in_now(s_tdata[114:83]),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_kind(kind), .out_ip(dip),
		.out_port(dport), .out_num(num), .out_seq(sq), .out_last(m_tlast)
	);

	assign m_tdata = {4'b0, sq, num, dport, dip, kind};

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench of the UDP session table: drives packets, predicts every reply
// from its own session table and checks the reply stream. Needs ust_pkg and
// udp_session_table_with_dedup_unit.

typedef struct {
	logic [3:0]  kind;
	logic [31:0] ip;
	logic [15:0] port;
	logic [31:0] num;
	logic [31:0] seqn;
	logic        lst;
} reply_t;

class reply_scoreboard;
	bit          act[ust_pkg::TABLE_ENTRIES];
	bit          ver[ust_pkg::TABLE_ENTRIES];
	logic [31:0] sip[ust_pkg::TABLE_ENTRIES];
	logic [15:0] sport[ust_pkg::TABLE_ENTRIES];
	logic [31:0] sid[ust_pkg::TABLE_ENTRIES];
	logic [31:0] sseq[ust_pkg::TABLE_ENTRIES];
	logic [31:0] sseen[ust_pkg::TABLE_ENTRIES];
	logic [31:0] id_next;
	logic [15:0] idle_limit;
	reply_t      pending[$];
	int          errors;

	function void clear();
		foreach (act[i]) begin
			act[i] = 0;
			ver[i] = 0;
		end
		id_next = ust_pkg::ID_RESET;
		idle_limit = ust_pkg::IDLE_RESET;
		errors = 0;
	endfunction

	function void push(logic [3:0] k, logic [31:0] ip, logic [15:0] pt,
		logic [31:0] n, logic [31:0] s);
		reply_t r;
		r.kind = k;
		r.ip = ip;
		r.port = pt;
		r.num = n;
		r.seqn = s;
		r.lst = 0;
		pending.push_back(r);
	endfunction

	function void note_packet(logic [2:0] op, logic [31:0] ip, logic [15:0] pt,
		logic [31:0] s, logic [31:0] now);
		int idx;
		int fr;
		logic [31:0] from;
		idx = -1;
		fr = -1;
		foreach (act[i])
			if (act[i] && (now - sseen[i]) > {16'd0, idle_limit}) begin
				act[i] = 0;
				ver[i] = 0;
			end
		if (op == ust_pkg::OP_TIME)
			return;
		if (op == ust_pkg::OP_MALFORMED) begin
			push(ust_pkg::K_MALFORMED, ip, pt, 0, 0);
		end else begin
			foreach (act[i])
				if (idx < 0 && act[i] && sip[i] == ip && sport[i] == pt)
					idx = i;
			if (op == ust_pkg::OP_HELLO) begin
				if (idx < 0) begin
					foreach (act[i])
						if (fr < 0 && !act[i])
							fr = i;
					from = id_next;
					id_next = id_next + 1;
					if (fr >= 0) begin
						idx = fr;
						act[idx] = 1;
						sid[idx] = from;
						sip[idx] = ip;
						sport[idx] = pt;
					end
				end
				if (idx < 0) begin
					push(ust_pkg::K_FULL, ip, pt, 0, 0);
				end else begin
					ver[idx] = 1;
					sseen[idx] = now;
					sseq[idx] = s;
					push(ust_pkg::K_WELCOME, ip, pt, sid[idx], s);
				end
			end else if (idx < 0 || !ver[idx]) begin
				push(ust_pkg::K_HANDSHAKE, ip, pt, 0, 0);
			end else begin
				sseen[idx] = now;
				if ($signed(s) <= $signed(sseq[idx])) begin
					push(ust_pkg::K_DUP, ip, pt, sid[idx], s);
				end else begin
					sseq[idx] = s;
					if (op == ust_pkg::OP_MSG) begin
						from = sid[idx];
						push(ust_pkg::K_ACK, ip, pt, from, s);
						foreach (act[i])
							if (i != idx && act[i] && ver[i])
								push(ust_pkg::K_CHAT, sip[i], sport[i], from, s);
					end else if (op == ust_pkg::OP_BYE) begin
						push(ust_pkg::K_BYE, ip, pt, sid[idx], s);
						act[idx] = 0;
						ver[idx] = 0;
					end else begin
						push(ust_pkg::K_UNKNOWN, ip, pt, sid[idx], s);
					end
				end
			end
		end
		pending[$].lst = 1;
	endfunction

	function void check_reply(logic [119:0] d, logic l);
		reply_t e;
		if (pending.size() == 0) begin
			$error("unexpected reply %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[3:0] !== e.kind) begin
			$error("reply_kind exp %0d got %0d", e.kind, d[3:0]);
			errors++;
		end
		if (d[35:4] !== e.ip) begin
			$error("dest_ip exp %h got %h", e.ip, d[35:4]);
			errors++;
		end
		if (d[51:36] !== e.port) begin
			$error("dest_port exp %h got %h", e.port, d[51:36]);
			errors++;
		end
		if (d[83:52] !== e.num) begin
			$error("client_number exp %h got %h", e.num, d[83:52]);
			errors++;
		end
		if (d[115:84] !== e.seqn) begin
			$error("seq_echo exp %h got %h", e.seqn, d[115:84]);
			errors++;
		end
		if (l !== e.lst) begin
			$error("last exp %0d got %0d", e.lst, l);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import ust_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	reply_scoreboard sb;
	logic [31:0] now_clock;
	logic [31:0] peer_ip[8];
	logic [15:0] peer_port[8];
	logic [31:0] peer_seq[8];
	int          gap_left;
	int          hold_cycles;
	int          idle_cycles;

	udp_session_table_with_dedup_unit i_dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver stall pattern, with an optional long hold.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0) || now_clock[5];
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_reply(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_packet(logic [2:0] op, logic [31:0] ip, logic [15:0] pt,
		logic [31:0] s, logic [31:0] now);
		if (gap_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			gap_left = $urandom_range(1, 12);
		end
		gap_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, now, s, pt, ip, op};
		do @(posedge clk); while (!s_tready);
		sb.note_packet(op, ip, pt, s, now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3 * TABLE_ENTRIES + 10) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd4 * REG_IDLE_LIMIT;
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.idle_limit = v;
	endtask

	task automatic random_phase(int count, int peers);
		int p;
		int r;
		logic [2:0] op;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, peers - 1);
			r = $urandom_range(0, 99);
			now_clock = now_clock + $urandom_range(0, 3);
			if (r < 20)
				op = OP_HELLO;
			else if (r < 65)
				op = OP_MSG;
			else if (r < 72)
				op = OP_BYE;
			else if (r < 78)
				op = 3'($urandom_range(4, 7));
			else if (r < 83)
				op = OP_TIME;
			else
				op = OP_MSG;
			if (r >= 83 && r < 90)
				peer_seq[p] = peer_seq[p] - $urandom_range(0, 2);
			else
				peer_seq[p] = peer_seq[p] + $urandom_range(1, 3);
			if (r >= 95) begin
				now_clock = now_clock + $urandom_range(0, 80);
				send_packet(3'($urandom), $urandom, 16'($urandom), $urandom, now_clock);
			end else begin
				send_packet(op, peer_ip[p], peer_port[p], peer_seq[p], now_clock);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_cycles = 0;
		idle_cycles = 0;
		gap_left = 0;
		now_clock = 32'hFFFF_FFF0;
		foreach (peer_ip[i]) begin
			peer_ip[i] = $urandom;
			peer_port[i] = 16'($urandom);
			peer_seq[i] = $urandom;
		end
		peer_ip[0] = 32'hFFFF_FFFF;
		peer_port[0] = 16'hFFFF;
		peer_ip[1] = 32'h0;
		peer_port[1] = 16'h0;
		peer_seq[1] = 32'h7FFF_FFFE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: handshake needed, malformed, welcome, dup, wrap of seq and time.
		send_packet(OP_MSG, peer_ip[0], peer_port[0], 32'd5, now_clock);
		send_packet(OP_MALFORMED, peer_ip[0], peer_port[0], 32'd5, now_clock);
		send_packet(OP_HELLO, peer_ip[0], peer_port[0], 32'h8000_0000, now_clock);
		send_packet(OP_HELLO, peer_ip[1], peer_port[1], 32'h7FFF_FFFE, now_clock);
		send_packet(OP_HELLO, peer_ip[2], peer_port[2], 32'd0, now_clock);
		send_packet(OP_MSG, peer_ip[1], peer_port[1], 32'h7FFF_FFFF, now_clock + 20);
		send_packet(OP_MSG, peer_ip[1], peer_port[1], 32'h7FFF_FFFF, now_clock + 20);
		send_packet(OP_MSG, peer_ip[0], peer_port[0], 32'hFFFF_FFFF, now_clock + 25);
		send_packet(3'd4, peer_ip[0], peer_port[0], 32'd1, now_clock + 25);
		send_packet(3'd6, peer_ip[0], peer_port[0], 32'd2, now_clock + 25);
		send_packet(3'd7, peer_ip[0], peer_port[0], 32'd3, now_clock + 25);
		send_packet(OP_HELLO, peer_ip[0], peer_port[0], 32'd0, now_clock + 25);
		send_packet(OP_BYE, peer_ip[0], peer_port[0], 32'd9, now_clock + 25);
		send_packet(OP_BYE, peer_ip[0], peer_port[0], 32'd10, now_clock + 25);
		send_packet(OP_TIME, '0, '0, '0, now_clock + 90);
		send_packet(OP_MSG, peer_ip[1], peer_port[1], 32'h7FFF_FFFF, now_clock + 90);
		now_clock = now_clock + 90;
		// Fill the table and overflow it, then broadcast to every session.
		for (int i = 0; i < TABLE_ENTRIES + 2; i++)
			send_packet(OP_HELLO, 32'hC0A8_0000 + i, 16'(i), 32'd0, now_clock);
		hold_cycles = 400;
		send_packet(OP_MSG, 32'hC0A8_0003, 16'd3, 32'd1, now_clock);
		send_packet(OP_MSG, 32'hC0A8_0004, 16'd4, 32'd1, now_clock);
		send_packet(OP_MSG, 32'hC0A8_0005, 16'd5, 32'd1, now_clock);
		drain();

		write_limit(16'd0);
		send_packet(OP_TIME, '0, '0, '0, now_clock + 1);
		now_clock = now_clock + 1;
		foreach (peer_seq[i])
			peer_seq[i] = 32'd100;
		random_phase(30, 4);
		drain();
		write_limit(16'hFFFF);
		random_phase(40, 8);
		drain();
		write_limit(16'd5);
		random_phase(40, 8);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[udp_session_table_with_dedup_unit.f]
sv/ust_pkg.sv
sv/ust_ctrl.sv
sv/ust_dp.sv
sv/udp_session_table_with_dedup_unit.sv
dv/tb_top.sv
